// ----- rtl/mfbt_pkg.sv -----
package mfbt_pkg;

    localparam logic [7:0] PRE_FIRST  = 8'hFF;
    localparam logic [7:0] PRE_SECOND = 8'hFE;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] CSUM_BASE  = 8'hFF;
    localparam logic [7:0] LEN_MIN    = 8'd1;
    localparam logic [7:0] LEN_MAX    = 8'd253;

    // Slot positions inside a job's word mask, in transmit order.
    localparam int SLOT_PRE0 = 0;
    localparam int SLOT_PRE1 = 1;
    localparam int SLOT_LEN  = 2;
    localparam int SLOT_DATA = 3;
    localparam int SLOT_ESC2 = 4;
    localparam int SLOT_CSUM = 5;
    localparam int NUM_SLOTS = 6;

    // One classified payload byte and everything it expands into.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           data;
        logic [7:0]           len;
        logic [7:0]           csum;
    } t_job;

    // Low half-bit carries the inverted data bit, high half-bit the bit itself.
    function automatic logic [15:0] manchester(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            w[2*k]   = ~b[k];
            w[2*k+1] = b[k];
        end
        return w;
    endfunction

endpackage

// ----- rtl/mfbt_front.sv -----
module mfbt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_frame_start,
    input  logic [7:0]    i_frame_length,
    output logic          o_push,
    output mfbt_pkg::t_job o_job
);

    logic [7:0] r_rem;
    logic [7:0] r_sum;
    logic [7:0] n_rem;
    logic [7:0] n_sum;

    logic [7:0] len_c;
    logic [7:0] rem_base;
    logic [7:0] sum_base;
    logic [7:0] rem_left;
    logic [7:0] sum_new;
    logic       frame_open;
    logic       escape;
    logic       closing;

    always_comb begin
        priority if (i_frame_length < mfbt_pkg::LEN_MIN) begin
            len_c = mfbt_pkg::LEN_MIN;
        end else if (i_frame_length > mfbt_pkg::LEN_MAX) begin
            len_c = mfbt_pkg::LEN_MAX;
        end else begin
            len_c = i_frame_length;
        end
    end

    assign rem_base   = i_frame_start ? len_c : r_rem;
    assign sum_base   = i_frame_start ? 8'd0 : r_sum;
    assign frame_open = i_frame_start || (r_rem != 8'd0);
    assign rem_left   = rem_base - 8'd1;
    assign sum_new    = sum_base + i_data_byte;
    assign closing    = (rem_left == 8'd0);
    assign escape     = (i_data_byte == mfbt_pkg::PRE_SECOND) ||
                        (i_data_byte == mfbt_pkg::PRE_FIRST);

    assign o_push = i_accept && frame_open;

    always_comb begin
        o_job.mask                      = '0;
        o_job.mask[mfbt_pkg::SLOT_PRE0] = i_frame_start;
        o_job.mask[mfbt_pkg::SLOT_PRE1] = i_frame_start;
        o_job.mask[mfbt_pkg::SLOT_LEN]  = i_frame_start;
        o_job.mask[mfbt_pkg::SLOT_DATA] = 1'b1;
        o_job.mask[mfbt_pkg::SLOT_ESC2] = escape;
        o_job.mask[mfbt_pkg::SLOT_CSUM] = closing;
        o_job.data                      = i_data_byte;
        o_job.len                       = len_c;
        o_job.csum                      = mfbt_pkg::CSUM_BASE - sum_new;
    end

    always_comb begin
        n_rem = r_rem;
        n_sum = r_sum;
        if (o_push) begin
            n_rem = rem_left;
            n_sum = closing ? 8'd0 : sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_sum <= '0;
        end else begin
            r_rem <= n_rem;
            r_sum <= n_sum;
        end
    end

endmodule

// ----- rtl/mfbt_queue.sv -----
module mfbt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfbt_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output mfbt_pkg::t_job o_job
);

    mfbt_pkg::t_job r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic           n_wr;
    logic           n_rd;
    logic [1:0]     n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = do_push ? ~r_wr : r_wr;
        n_rd    = do_pop ? ~r_rd : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/mfbt_back.sv -----
module mfbt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mfbt_pkg::t_job i_job,
    output logic           o_pop,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [15:0]    o_code_word,
    output logic [7:0]     o_raw_byte,
    output logic           o_frame_end,
    output logic           o_last
);

    logic [mfbt_pkg::NUM_SLOTS-1:0] r_todo;
    logic [mfbt_pkg::NUM_SLOTS-1:0] n_todo;
    mfbt_pkg::t_job                 r_job;
    logic                           r_valid;
    logic [15:0]                    r_code;
    logic [7:0]                     r_raw;
    logic                           r_end;
    logic                           r_last;

    logic                           advance;
    logic                           busy;
    mfbt_pkg::t_job                 cur_job;
    logic [mfbt_pkg::NUM_SLOTS-1:0] cur_mask;
    logic [mfbt_pkg::NUM_SLOTS-1:0] pick;
    logic [mfbt_pkg::NUM_SLOTS-1:0] rest;
    logic                           have_word;
    logic [7:0]                     word;

    assign advance   = !r_valid || i_out_ready;
    assign busy      = (r_todo != '0);
    assign cur_job   = busy ? r_job : i_job;
    assign cur_mask  = busy ? r_todo : i_job.mask;
    assign have_word = busy || !i_empty;
    assign o_pop     = advance && !busy && !i_empty;

    // Lowest pending slot goes out first.
    assign pick = cur_mask & (-cur_mask);
    assign rest = cur_mask & ~pick;

    always_comb begin
        priority if (pick[mfbt_pkg::SLOT_PRE0]) begin
            word = mfbt_pkg::PRE_FIRST;
        end else if (pick[mfbt_pkg::SLOT_PRE1]) begin
            word = mfbt_pkg::PRE_SECOND;
        end else if (pick[mfbt_pkg::SLOT_LEN]) begin
            word = cur_job.len;
        end else if (pick[mfbt_pkg::SLOT_DATA]) begin
            word = cur_job.mask[mfbt_pkg::SLOT_ESC2] ? mfbt_pkg::ESC_BYTE : cur_job.data;
        end else if (pick[mfbt_pkg::SLOT_ESC2]) begin
            word = cur_job.data ^ mfbt_pkg::ESC_XOR;
        end else begin
            word = cur_job.csum;
        end
    end

    always_comb begin
        n_todo = r_todo;
        if (advance && have_word) begin
            n_todo = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (advance && have_word) begin
            r_code <= mfbt_pkg::manchester(word);
            r_raw  <= word;
            r_end  <= pick[mfbt_pkg::SLOT_CSUM];
            r_last <= (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_todo  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_todo <= n_todo;
            if (advance) begin
                r_valid <= have_word;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_code_word = r_code;
    assign o_raw_byte  = r_raw;
    assign o_frame_end = r_end;
    assign o_last      = r_last;

endmodule

// ----- rtl/manchester_framed_byte_transmitter_top.sv -----
// Framed Manchester byte transmitter.
// The slave channel takes one payload byte per request. The first byte of a
// frame has tuser set and carries the frame length, which is clamped to 1..253.
// The master channel returns one Manchester code word per request together with
// the framed byte it encodes. A frame goes out as 0xFF, 0xFE, the length, the
// payload with 0xFE and 0xFF escaped as 0x7D and the byte XOR 0x20, and then
// the checksum, 0xFF minus the 8-bit payload sum, which is flagged in tuser.
// tlast marks the final word that belongs to one input request.
// Bytes that arrive while no frame is open are accepted and dropped.
// With the queue and the output idle, a byte's first word goes through the
// queue and the output register before it is valid on the master channel.
// With the receiver ready, the back end sends one word per cycle: a plain byte
// is one word, an escaped byte two; a frame opening adds three, a closing one.
// The front end classifies a byte in the cycle it arrives and places it in a
// two-entry queue, so input is taken while words still wait on the output.
// When the receiver stalls, the output register holds its word, the queue
// fills, and then tready drops. Reset empties the queue and output register
// and closes any open frame.
module manchester_framed_byte_transmitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data_byte, [15:8] frame_length
    input  logic        i_s_tuser,   // [0] frame_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] code_word, [23:16] raw_byte
    output logic        o_m_tuser,   // [0] frame_end
    output logic        o_m_tlast
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    mfbt_pkg::t_job job_in;
    mfbt_pkg::t_job job_out;
    logic [15:0]    code_word;
    logic [7:0]     raw_byte;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    mfbt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_s_tdata[7:0]),
        .i_frame_start  (i_s_tuser),
        .i_frame_length (i_s_tdata[15:8]),
        .o_push         (push),
        .o_job          (job_in)
    );

    mfbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    mfbt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_code_word (code_word),
        .o_raw_byte  (raw_byte),
        .o_frame_end (o_m_tuser),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {raw_byte, code_word};

endmodule

// ----- tb/tb_manchester_framed_byte_transmitter_top.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the framed Manchester byte transmitter.
// Payload bytes go in on the slave channel, and every accepted request runs
// through a local model of the framer. That model produces the code words the
// block should send, and the monitor compares each word on the master channel
// with the oldest word still waited for.
module tb_manchester_framed_byte_transmitter_top;

    localparam int NUM_DIRECTED = 17;
    localparam int HOLD_CYCLES  = 300;   // length of the long receiver hold-off
    localparam int DRAIN_CYCLES = 16;    // quiet cycles after the last word

    // One word on the master channel, field by field.
    typedef struct packed {
        logic [15:0] code_word;
        logic [7:0]  raw_byte;
        logic        frame_end;
        logic        last;
    } t_line_word;

    // One stimulus row. Rows with golden set carry the framed bytes typed in,
    // first byte in the highest used byte of gold_raw, and gold_end says the
    // final typed byte is a checksum.
    typedef struct {
        logic [7:0]  data;
        logic        start;
        logic [7:0]  len;
        logic        golden;
        int          gold_n;
        logic [47:0] gold_raw;
        logic        gold_end;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    manchester_framed_byte_transmitter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] data_byte, [15:8] frame_length
        .i_s_tuser  (i_s_tuser),   // [0] frame_start
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [15:0] code_word, [23:16] raw_byte
        .o_m_tuser  (o_m_tuser),   // [0] frame_end
        .o_m_tlast  (o_m_tlast)
    );

    // Framer model state: payload bytes still owed in the open frame and the
    // running 8-bit sum of the raw payload bytes sent so far.
    logic [7:0] bytes_left;
    logic [7:0] payload_sum;

    t_line_word item_words[$];      // words caused by the request just accepted
    t_line_word expected_words[$];  // words the block still owes, oldest first
    t_stim_row  directed[NUM_DIRECTED];

    int mismatch_cnt;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    bit hold_request;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Each data bit becomes two half-bit levels: a 1 is low then high, a 0 is
    // high then low, and the lower index goes out on the line first.
    function automatic logic [15:0] line_levels(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            w[2*k +: 2] = b[k] ? 2'b10 : 2'b01;
        end
        return w;
    endfunction

    task automatic add_word(input logic [7:0] raw, input logic is_end);
        t_line_word w;
        w.code_word = line_levels(raw);
        w.raw_byte  = raw;
        w.frame_end = is_end;
        w.last      = 1'b0;
        item_words.push_back(w);
    endtask

    // Works out the words one accepted request causes and advances the model.
    task automatic predict_item(input logic [7:0] data, input logic start,
                                input logic [7:0] len);
        logic [7:0] clamped;
        item_words.delete();
        if (start) begin
            // A start always opens a fresh frame, even over an open one.
            if (len < mfbt_pkg::LEN_MIN) begin
                clamped = mfbt_pkg::LEN_MIN;
            end else if (len > mfbt_pkg::LEN_MAX) begin
                clamped = mfbt_pkg::LEN_MAX;
            end else begin
                clamped = len;
            end
            bytes_left  = clamped;
            payload_sum = '0;
            add_word(mfbt_pkg::PRE_FIRST, 1'b0);
            add_word(mfbt_pkg::PRE_SECOND, 1'b0);
            add_word(clamped, 1'b0);
        end
        // Without a start and with no frame open the byte is simply dropped.
        if (start || bytes_left != 0) begin
            // Bytes that look like the preamble are escaped.
            if (data == mfbt_pkg::PRE_FIRST || data == mfbt_pkg::PRE_SECOND) begin
                add_word(mfbt_pkg::ESC_BYTE, 1'b0);
                add_word(data ^ mfbt_pkg::ESC_XOR, 1'b0);
            end else begin
                add_word(data, 1'b0);
            end
            payload_sum = payload_sum + data;
            bytes_left  = bytes_left - 8'd1;
            if (bytes_left == 0) begin
                add_word(mfbt_pkg::CSUM_BASE - payload_sum, 1'b1);
                payload_sum = '0;
            end
            item_words[item_words.size()-1].last = 1'b1;
        end
    endtask

    // Offers one request, starting and ending at a falling edge. Valid stays
    // high across back-to-back requests, so it is never lowered and raised
    // again in one time step.
    task automatic send_item(input t_stim_row row);
        logic [47:0] shifted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {row.len, row.data};
        i_s_tuser  <= row.start;
        do @(posedge i_clk); while (!o_s_tready);
        // The model always runs so its state follows the block; on a golden
        // row the typed bytes stand in for its words.
        predict_item(row.data, row.start, row.len);
        if (row.golden) begin
            item_words.delete();
            for (int k = 0; k < row.gold_n; k++) begin
                shifted = row.gold_raw >> (8 * (row.gold_n - 1 - k));
                add_word(shifted[7:0], row.gold_end && (k == row.gold_n - 1));
            end
            if (row.gold_n > 0) begin
                item_words[item_words.size()-1].last = 1'b1;
            end
        end
        foreach (item_words[k]) begin
            expected_words.push_back(item_words[k]);
        end
        @(negedge i_clk);
    endtask

    // Payload bytes lean toward the preamble values and the escape byte so
    // the escape path gets plenty of traffic.
    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            return $urandom_range(1) ? mfbt_pkg::PRE_FIRST : mfbt_pkg::PRE_SECOND;
        end else if (r < 32) begin
            return mfbt_pkg::ESC_BYTE;
        end
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed frames of short length with random content. Some
    // frames are cut short by the next start, a few ask for lengths that the
    // block must clamp, and stray bytes fall between frames as noise that
    // does not count toward the total.
    task automatic run_random(input int items);
        int sent;
        int frame_len;
        int body;
        int r;
        t_stim_row row;
        sent = 0;
        row.golden   = 1'b0;
        row.gold_n   = 0;
        row.gold_raw = '0;
        row.gold_end = 1'b0;
        while (sent < items) begin
            if (bytes_left == 0 && $urandom_range(99) < 15) begin
                row.data  = 8'($urandom_range(255));
                row.start = 1'b0;
                row.len   = 8'($urandom_range(255));
                send_item(row);
            end else begin
                r = $urandom_range(99);
                if (r < 70) begin
                    frame_len = $urandom_range(6, 1);
                end else if (r < 85) begin
                    frame_len = $urandom_range(20, 7);
                end else begin
                    frame_len = $urandom_range(255);
                end
                body = (frame_len == 0) ? 1 : (frame_len > 253 ? 253 : frame_len);
                if ($urandom_range(99) < 10) begin
                    body = $urandom_range(body, 1);
                end
                if (body > items - sent) begin
                    body = items - sent;
                end
                for (int j = 0; j < body; j++) begin
                    row.data  = pick_payload();
                    row.start = (j == 0);
                    row.len   = (j == 0) ? 8'(frame_len) : 8'($urandom_range(255));
                    send_item(row);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stalls per phase, plus one long hold-off on request
    // that is counted down here, one cycle at a time.
    initial begin
        i_m_tready = 1'b0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Every word taken from the block is checked against the oldest one owed.
    always @(posedge i_clk) begin : check_words
        t_line_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: raw_byte %h, code_word %h",
                       o_m_tdata[23:16], o_m_tdata[15:0]);
                mismatch_cnt++;
            end else begin
                want = expected_words.pop_front();
                if (o_m_tdata[15:0] !== want.code_word) begin
                    $error("code_word: expected %h, got %h",
                           want.code_word, o_m_tdata[15:0]);
                    mismatch_cnt++;
                end
                if (o_m_tdata[23:16] !== want.raw_byte) begin
                    $error("raw_byte: expected %h, got %h",
                           want.raw_byte, o_m_tdata[23:16]);
                    mismatch_cnt++;
                end
                if (o_m_tuser !== want.frame_end) begin
                    $error("frame_end: expected %b, got %b", want.frame_end, o_m_tuser);
                    mismatch_cnt++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_m_tlast);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b0;
        bytes_left   = '0;
        payload_sum  = '0;
        mismatch_cnt = 0;

        // Directed rows: data, start, length, golden, count, bytes, checksum.
        // A byte before any frame is dropped.
        directed[0]  = '{8'h55, 1'b0, 8'h00, 1'b1, 0, 48'h0, 1'b0};
        // Single-byte frame: the checksum follows in the same request.
        directed[1]  = '{8'h00, 1'b1, 8'h01, 1'b1, 5, 48'hFF_FE_01_00_FF, 1'b1};
        // Length 0 counts as 1; an escaped byte makes this the widest request.
        directed[2]  = '{8'hFF, 1'b1, 8'h00, 1'b1, 6, 48'hFF_FE_01_7D_DF_00, 1'b1};
        // Length above the maximum is clamped to 253.
        directed[3]  = '{8'hAA, 1'b1, 8'hFF, 1'b1, 4, 48'hFF_FE_FD_AA, 1'b0};
        directed[4]  = '{8'hFE, 1'b0, 8'h5A, 1'b0, 0, 48'h0, 1'b0};
        directed[5]  = '{8'hFF, 1'b0, 8'hA5, 1'b0, 0, 48'h0, 1'b0};
        // The escape byte itself goes out unescaped.
        directed[6]  = '{8'h7D, 1'b0, 8'h00, 1'b0, 0, 48'h0, 1'b0};
        // A start inside the open frame abandons it without a checksum.
        directed[7]  = '{8'hFE, 1'b1, 8'h02, 1'b1, 5, 48'hFF_FE_02_7D_DE, 1'b0};
        directed[8]  = '{8'h01, 1'b0, 8'hFF, 1'b1, 2, 48'h01_00, 1'b1};
        directed[9]  = '{8'h33, 1'b0, 8'h00, 1'b1, 0, 48'h0, 1'b0};
        directed[10] = '{8'h80, 1'b1, 8'hFD, 1'b0, 0, 48'h0, 1'b0};
        directed[11] = '{8'hFD, 1'b0, 8'h00, 1'b0, 0, 48'h0, 1'b0};
        directed[12] = '{8'h20, 1'b0, 8'hFF, 1'b0, 0, 48'h0, 1'b0};
        directed[13] = '{8'h0F, 1'b1, 8'h03, 1'b0, 0, 48'h0, 1'b0};
        directed[14] = '{8'hF0, 1'b0, 8'h00, 1'b0, 0, 48'h0, 1'b0};
        // Closing byte that needs escaping, then the checksum.
        directed[15] = '{8'hFF, 1'b0, 8'h00, 1'b0, 0, 48'h0, 1'b0};
        // Length 254 clamps too; this frame is left open for the random part.
        directed[16] = '{8'hC3, 1'b1, 8'hFE, 1'b0, 0, 48'h0, 1'b0};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_item(directed[i]);
        end

        // Random phases: no idling, sender idle, receiver stalling, both.
        run_random(40);
        tx_idle_pct  = 64;
        run_random(40);
        tx_idle_pct  = 0;
        rx_stall_pct = 64;
        run_random(40);
        tx_idle_pct  = 23;
        rx_stall_pct = 23;
        run_random(40);

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering, so the queue fills and tready drops.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        run_random(40);

        i_s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("** manchester_framed_byte_transmitter_top: PASSED **");
        end else begin
            $display("** manchester_framed_byte_transmitter_top: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("** manchester_framed_byte_transmitter_top: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mfbt_pkg.sv
rtl/mfbt_front.sv
rtl/mfbt_queue.sv
rtl/mfbt_back.sv
rtl/manchester_framed_byte_transmitter_top.sv
tb/tb_manchester_framed_byte_transmitter_top.sv
